[src/quaternion_to_euler_angles_top_assert.svh]
// Assertion macros shared by the quaternion-to-Euler checker.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q2e implication check failed");

// Implication checked on every clock edge, reset included.
`define Q2E_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("q2e check failed");

`endif

[src/q2e_pkg.sv]
// Shared constants and the arctangent table for the quaternion-to-Euler pipeline.
`timescale 1ns / 1ps
package q2e_pkg;

  // CORDIC operand width at the input, internal width, accumulator and angle widths
  localparam int CW = 34;
  localparam int IW = 43;
  localparam int AW = 25;
  localparam int OW = 17;
  localparam int CORDIC_STEPS = 18;
  localparam int NORM_STEPS = 6;
  // normalized magnitude lands in [2^(NORM_TOP-1), 2^NORM_TOP)
  localparam int NORM_TOP = 40;

  // half turn in 1/256 of a hundredth of a degree
  localparam logic signed [AW-1:0] HALF_TURN = 25'sd4608000;

  // isqrt of a 62-bit radicand, one result bit per stage
  localparam int RW = 62;
  localparam int SQRT_STEPS = 31;

  localparam int YAW_LIM = 20000;
  localparam int PITCH_LIM = 9000;
  localparam int ROLL_LIM = 18000;

  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0: v = 25'sd1152000;
      5'd1: v = 25'sd680065;
      5'd2: v = 25'sd359328;
      5'd3: v = 25'sd182400;
      5'd4: v = 25'sd91554;
      5'd5: v = 25'sd45822;
      5'd6: v = 25'sd22916;
      5'd7: v = 25'sd11459;
      5'd8: v = 25'sd5730;
      5'd9: v = 25'sd2865;
      5'd10: v = 25'sd1432;
      5'd11: v = 25'sd716;
      5'd12: v = 25'sd358;
      5'd13: v = 25'sd179;
      5'd14: v = 25'sd90;
      5'd15: v = 25'sd45;
      5'd16: v = 25'sd22;
      5'd17: v = 25'sd11;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/q2e_cordic.sv]
// Pipelined vectoring CORDIC: atan2(n, d) in hundredths of a degree.
`timescale 1ns / 1ps
module q2e_cordic (
  input  logic                             clk,
  input  logic signed [q2e_pkg::CW-1:0]    n_i,
  input  logic signed [q2e_pkg::CW-1:0]    d_i,
  output logic signed [q2e_pkg::OW-1:0]    ang_o
);

  localparam int IW = q2e_pkg::IW;
  localparam int AW = q2e_pkg::AW;
  localparam int CW = q2e_pkg::CW;
  localparam int NN = q2e_pkg::NORM_STEPS;
  localparam int NS = q2e_pkg::NORM_STEPS + q2e_pkg::CORDIC_STEPS;

  logic signed [IW-1:0] n_r   [0:NS];
  logic signed [IW-1:0] d_r   [0:NS];
  logic signed [AW-1:0] acc_r [0:NS];
  logic                 z_r   [0:NS];
  logic        [IW-1:0] m_r   [0:NN];
  logic signed [q2e_pkg::OW-1:0] ang_r;

  logic signed [IW-1:0] n_ext, d_ext, n0, d0;
  logic        [IW-1:0] n0_mag;

  // pre-rotate by a half turn when d is negative
  always_comb begin
    n_ext  = {{(IW-CW){n_i[CW-1]}}, n_i};
    d_ext  = {{(IW-CW){d_i[CW-1]}}, d_i};
    n0     = d_ext < 0 ? -n_ext : n_ext;
    d0     = d_ext < 0 ? -d_ext : d_ext;
    n0_mag = n0 < 0 ? IW'(-n0) : IW'(n0);
  end

  always_ff @(posedge clk) begin
    n_r[0]   <= n0;
    d_r[0]   <= d0;
    m_r[0]   <= n0_mag > IW'(d0) ? n0_mag : IW'(d0);
    z_r[0]   <= (n_i == '0) && (d_i == '0);
    acc_r[0] <= d_i < 0 ? (n_i >= 0 ? q2e_pkg::HALF_TURN : -q2e_pkg::HALF_TURN) : '0;
  end

  // binary search of the left shift: 32, 16, 8, 4, 2, 1
  for (genvar j = 0; j < NN; j++) begin : g_norm
    localparam int K = 32 >> j;
    localparam logic [IW-1:0] LIM = IW'(1) << (q2e_pkg::NORM_TOP - K);
    always_ff @(posedge clk) begin
      if (m_r[j] < LIM) begin
        n_r[j+1] <= n_r[j] <<< K;
        d_r[j+1] <= d_r[j] <<< K;
        m_r[j+1] <= m_r[j] << K;
      end else begin
        n_r[j+1] <= n_r[j];
        d_r[j+1] <= d_r[j];
        m_r[j+1] <= m_r[j];
      end
      acc_r[j+1] <= acc_r[j];
      z_r[j+1]   <= z_r[j];
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < q2e_pkg::CORDIC_STEPS; i++) begin : g_iter
    localparam int S = NN + i;
    always_ff @(posedge clk) begin
      if (n_r[S] > 0) begin
        d_r[S+1]   <= d_r[S] + (n_r[S] >>> i);
        n_r[S+1]   <= n_r[S] - (d_r[S] >>> i);
        acc_r[S+1] <= acc_r[S] + q2e_pkg::atan_tab(5'(i));
      end else begin
        d_r[S+1]   <= d_r[S] - (n_r[S] >>> i);
        n_r[S+1]   <= n_r[S] + (d_r[S] >>> i);
        acc_r[S+1] <= acc_r[S] - q2e_pkg::atan_tab(5'(i));
      end
      z_r[S+1] <= z_r[S];
    end
  end

  logic signed [AW-1:0] acc_rnd;
  assign acc_rnd = acc_r[NS] + AW'(128);

  // round to hundredths; the zero vector gives zero
  always_ff @(posedge clk) begin
    ang_r <= z_r[NS] ? '0 : acc_rnd[AW-1:8];
  end

  assign ang_o = ang_r;

endmodule

[src/quaternion_to_euler_angles_top.sv]
// Top level: Z-Y-X Euler angles from a Q1.15 quaternion, fully pipelined.
// Results strobe out on out_strobe in the order the words were taken at start.
// Throughput: one word per cycle; busy stays low. Depth is set by the 31-stage
// isqrt feeding the pitch CORDIC (26 stages), yaw and roll delayed to match.
// Reset: rst_n synchronous low clears all valid bits and loads yaw_offset 850.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               cfg_wr_en,
  input  logic signed [11:0] cfg_wr_data,
  output logic               out_strobe,
  output logic signed [15:0] out_yaw_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_roll_angle,
  output logic               out_pitch_clamped
);

  localparam int CW = q2e_pkg::CW;
  localparam int OW = q2e_pkg::OW;
  localparam int RW = q2e_pkg::RW;
  localparam int NSQ = q2e_pkg::SQRT_STEPS;
  // yaw and roll finish at stage 28, pitch at stage 61
  localparam int YR_DLY = 33;
  localparam int CL_DLY = 59;
  localparam int VLD_LEN = 61;

  // Never hold off the sender: one word enters each cycle.
  assign busy = 1'b0;

  logic               acc_in;
  assign acc_in = start && !busy;

  // Yaw offset register; write it only while the pipe is empty.
  logic signed [11:0] yaw_off_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_off_r <= 12'sd850;
    end else if (cfg_wr_en) begin
      yaw_off_r <= cfg_wr_data;
    end
  end

  // Valid bits travel with the data; bit k marks stage k+1.
  logic [VLD_LEN-1:0] vld_r;
  logic               strobe_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      vld_r    <= {vld_r[VLD_LEN-2:0], acc_in};
      strobe_r <= vld_r[VLD_LEN-1];
    end
  end

  // Stage 1: all ten component products, exact Q2.30.
  logic signed [31:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r, p_xy_r;
  logic signed [31:0] p_wz_r, p_wx_r, p_yz_r, p_xz_r, p_wy_r;
  always_ff @(posedge clk) begin
    p_ww_r <= in_quat_w * in_quat_w;
    p_xx_r <= in_quat_x * in_quat_x;
    p_yy_r <= in_quat_y * in_quat_y;
    p_zz_r <= in_quat_z * in_quat_z;
    p_xy_r <= in_quat_x * in_quat_y;
    p_wz_r <= in_quat_w * in_quat_z;
    p_wx_r <= in_quat_w * in_quat_x;
    p_yz_r <= in_quat_y * in_quat_z;
    p_xz_r <= in_quat_x * in_quat_z;
    p_wy_r <= in_quat_w * in_quat_y;
  end

  // Stage 2: numerators, denominators and the saturated asin argument.
  logic signed [CW-1:0] yaw_n_r, yaw_d_r, roll_n_r, roll_d_r;
  logic signed [31:0]   a2_r;
  logic                 clamp_r;
  logic signed [CW-1:0] a_raw;
  localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1 <<< 30);

  assign a_raw = (CW'(p_xz_r) - CW'(p_wy_r)) <<< 1;

  always_ff @(posedge clk) begin
    yaw_n_r  <= (CW'(p_xy_r) + CW'(p_wz_r)) <<< 1;
    yaw_d_r  <= CW'(p_ww_r) + CW'(p_xx_r) - CW'(p_yy_r) - CW'(p_zz_r);
    roll_n_r <= (CW'(p_wx_r) + CW'(p_yz_r)) <<< 1;
    roll_d_r <= CW'(p_ww_r) - CW'(p_xx_r) - CW'(p_yy_r) + CW'(p_zz_r);
    if (a_raw > ONE_Q30) begin
      a2_r    <= 32'(ONE_Q30);
      clamp_r <= 1'b1;
    end else if (a_raw < -ONE_Q30) begin
      a2_r    <= 32'(-ONE_Q30);
      clamp_r <= 1'b1;
    end else begin
      a2_r    <= a_raw[31:0];
      clamp_r <= 1'b0;
    end
  end

  // Stage 3: a squared, from the magnitude (at most 2^30).
  logic [30:0]        a_mag;
  logic [RW-1:0]      aa_r;
  logic signed [31:0] a3_r;
  assign a_mag = a2_r < 0 ? 31'(-a2_r) : a2_r[30:0];
  always_ff @(posedge clk) begin
    aa_r <= a_mag * a_mag;
    a3_r <= a2_r;
  end

  // Stage 4 is entry 0 of the isqrt line: radicand 2^60 - a*a.
  logic [RW-1:0]      sq_rem_r  [0:NSQ];
  logic [RW-1:0]      sq_root_r [0:NSQ];
  logic signed [31:0] sq_a_r    [0:NSQ];
  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= (RW'(1) << 60) - aa_r;
    sq_root_r[0] <= '0;
    sq_a_r[0]    <= a3_r;
  end

  // Stages 5..35: one result bit per stage, trial subtract.
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2*k);
    logic [RW-1:0] trial;
    assign trial = sq_root_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (sq_rem_r[k] >= trial) begin
        sq_rem_r[k+1]  <= sq_rem_r[k] - trial;
        sq_root_r[k+1] <= (sq_root_r[k] >> 1) + BIT;
      end else begin
        sq_rem_r[k+1]  <= sq_rem_r[k];
        sq_root_r[k+1] <= sq_root_r[k] >> 1;
      end
      sq_a_r[k+1] <= sq_a_r[k];
    end
  end

  // Three CORDICs: yaw and roll start at stage 3, pitch at stage 36.
  logic signed [OW-1:0] yaw_ang, roll_ang, pitch_ang;
  logic signed [CW-1:0] pitch_n, pitch_d;
  assign pitch_n = CW'(sq_a_r[NSQ]);
  assign pitch_d = {3'b000, sq_root_r[NSQ][30:0]};

  q2e_cordic u_yaw (
    .clk   (clk),
    .n_i   (yaw_n_r),
    .d_i   (yaw_d_r),
    .ang_o (yaw_ang)
  );

  q2e_cordic u_roll (
    .clk   (clk),
    .n_i   (roll_n_r),
    .d_i   (roll_d_r),
    .ang_o (roll_ang)
  );

  q2e_cordic u_pitch (
    .clk   (clk),
    .n_i   (pitch_n),
    .d_i   (pitch_d),
    .ang_o (pitch_ang)
  );

  // Hold yaw and roll until pitch catches up; carry the clamp flag along.
  logic signed [OW-1:0] yaw_dly_r  [0:YR_DLY-1];
  logic signed [OW-1:0] roll_dly_r [0:YR_DLY-1];
  logic [CL_DLY-1:0]    clamp_dly_r;
  always_ff @(posedge clk) begin
    yaw_dly_r[0]  <= yaw_ang;
    roll_dly_r[0] <= roll_ang;
    clamp_dly_r   <= {clamp_dly_r[CL_DLY-2:0], clamp_r};
  end
  for (genvar t = 1; t < YR_DLY; t++) begin : g_dly
    always_ff @(posedge clk) begin
      yaw_dly_r[t]  <= yaw_dly_r[t-1];
      roll_dly_r[t] <= roll_dly_r[t-1];
    end
  end

  // Stage 62: subtract the offset, negate pitch, saturate all three.
  logic signed [17:0] yaw_diff, pitch_neg, roll_ext;
  logic signed [15:0] yaw_sat, roll_sat;
  logic signed [14:0] pitch_sat;
  always_comb begin
    yaw_diff  = 18'(yaw_dly_r[YR_DLY-1]) - 18'(yaw_off_r);
    pitch_neg = -18'(pitch_ang);
    roll_ext  = 18'(roll_dly_r[YR_DLY-1]);
    if (yaw_diff > 18'(q2e_pkg::YAW_LIM)) begin
      yaw_sat = 16'(q2e_pkg::YAW_LIM);
    end else if (yaw_diff < -18'(q2e_pkg::YAW_LIM)) begin
      yaw_sat = -16'(q2e_pkg::YAW_LIM);
    end else begin
      yaw_sat = yaw_diff[15:0];
    end
    if (pitch_neg > 18'(q2e_pkg::PITCH_LIM)) begin
      pitch_sat = 15'(q2e_pkg::PITCH_LIM);
    end else if (pitch_neg < -18'(q2e_pkg::PITCH_LIM)) begin
      pitch_sat = -15'(q2e_pkg::PITCH_LIM);
    end else begin
      pitch_sat = pitch_neg[14:0];
    end
    if (roll_ext > 18'(q2e_pkg::ROLL_LIM)) begin
      roll_sat = 16'(q2e_pkg::ROLL_LIM);
    end else if (roll_ext < -18'(q2e_pkg::ROLL_LIM)) begin
      roll_sat = -16'(q2e_pkg::ROLL_LIM);
    end else begin
      roll_sat = roll_ext[15:0];
    end
  end

  logic signed [15:0] yaw_out_r, roll_out_r;
  logic signed [14:0] pitch_out_r;
  logic               clamp_out_r;
  always_ff @(posedge clk) begin
    yaw_out_r   <= yaw_sat;
    pitch_out_r <= pitch_sat;
    roll_out_r  <= roll_sat;
    clamp_out_r <= clamp_dly_r[CL_DLY-1];
  end

  assign out_strobe        = strobe_r;
  assign out_yaw_angle     = yaw_out_r;
  assign out_pitch_angle   = pitch_out_r;
  assign out_roll_angle    = roll_out_r;
  assign out_pitch_clamped = clamp_out_r;

endmodule

[src/q2e_chk.sv]
// Port-level checker for the quaternion-to-Euler top, bound to every instance.
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_top_assert.svh"
module q2e_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic signed [15:0] out_yaw_angle,
  input logic signed [14:0] out_pitch_angle,
  input logic signed [15:0] out_roll_angle
);

  // a strobe traces back to a word taken at start while busy was low
  `Q2E_ASSERT_IMPL(a_strobe_src, out_strobe, $past(start && !busy, 62))
  // no word comes out the cycle after reset
  `Q2E_ASSERT_ALWAYS(a_rst_quiet, $past(!rst_n), !out_strobe)
  `Q2E_ASSERT_IMPL(a_pitch_rng, out_strobe,
    (out_pitch_angle <= 15'sd9000) && (out_pitch_angle >= -15'sd9000))
  `Q2E_ASSERT_IMPL(a_yr_rng, out_strobe,
    (out_yaw_angle <= 16'sd20000) && (out_yaw_angle >= -16'sd20000) &&
    (out_roll_angle <= 16'sd18000) && (out_roll_angle >= -16'sd18000))

endmodule

bind quaternion_to_euler_angles_top q2e_chk u_q2e_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_yaw_angle   (out_yaw_angle),
  .out_pitch_angle (out_pitch_angle),
  .out_roll_angle  (out_roll_angle)
);

[test/quaternion_to_euler_angles_top_tb.sv]
// Self-checking testbench for the quaternion to Z-Y-X Euler angle pipeline.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top_tb;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_quat_w;
  logic signed [15:0] in_quat_x;
  logic signed [15:0] in_quat_y;
  logic signed [15:0] in_quat_z;
  logic               cfg_wr_en;
  logic signed [11:0] cfg_wr_data;
  logic               out_strobe;
  logic signed [15:0] out_yaw_angle;
  logic signed [14:0] out_pitch_angle;
  logic signed [15:0] out_roll_angle;
  logic               out_pitch_clamped;

  quaternion_to_euler_angles_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_quat_w         (in_quat_w),
    .in_quat_x         (in_quat_x),
    .in_quat_y         (in_quat_y),
    .in_quat_z         (in_quat_z),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_strobe        (out_strobe),
    .out_yaw_angle     (out_yaw_angle),
    .out_pitch_angle   (out_pitch_angle),
    .out_roll_angle    (out_roll_angle),
    .out_pitch_clamped (out_pitch_clamped)
  );

  // Pipeline depth of the top level, plus margin for draining.
  localparam int PIPE_DEPTH = 62;
  localparam int SETTLE     = PIPE_DEPTH + 8;
  // Idle cycles (nothing taken, nothing returned) before giving up.
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1700;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } angles_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 typed;   // expected angles given in the row
    angles_t            angles;
  } quat_row_t;

  angles_t            angles_pending[$];
  logic signed [11:0] yaw_offset_copy;
  int                 fail_count;
  int                 stall_count;
  bit                 taken_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Angle of one vector in 1/256 hundredths of a degree, then rounded.
  function automatic longint vector_angle(longint n, longint d);
    longint acc, dn, dd;
    longint unsigned m, an, ad;
    acc = 0;
    if (n == 0 && d == 0) return 0;
    if (d < 0) begin
      acc = (n >= 0) ? 64'sd4608000 : -64'sd4608000;
      d = -d;
      n = -n;
    end
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    m = (an > ad) ? an : ad;
    while (m < (64'd1 << 39)) begin
      n = n * 2;
      d = d * 2;
      m = m << 1;
    end
    for (int i = 0; i < q2e_pkg::CORDIC_STEPS; i++) begin
      dn = d >>> i;
      dd = n >>> i;
      if (n > 0) begin
        d += dd;
        n -= dn;
        acc += longint'(q2e_pkg::atan_tab(5'(i)));
      end else begin
        d -= dd;
        n += dn;
        acc -= longint'(q2e_pkg::atan_tab(5'(i)));
      end
    end
    return (acc + 128) >>> 8;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic angles_t euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                       logic signed [15:0] qy, logic signed [15:0] qz);
    longint  w, x, y, z, a, yaw, pitch, roll;
    angles_t r;
    w = qw; x = qx; y = qy; z = qz;
    r.clamped = 1'b0;
    yaw  = vector_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
    roll = vector_angle(2 * (w * x + y * z), w * w - x * x - y * y + z * z);
    a = 2 * (x * z - w * y);
    if (a > (64'sd1 << 30)) begin
      a = 64'sd1 << 30;
      r.clamped = 1'b1;
    end else if (a < -(64'sd1 << 30)) begin
      a = -(64'sd1 << 30);
      r.clamped = 1'b1;
    end
    pitch = -vector_angle(a, longint'(root_floor((64'd1 << 60) - longint'(a * a))));
    r.yaw   = 16'(clip(yaw - longint'(yaw_offset_copy), q2e_pkg::YAW_LIM));
    r.pitch = 15'(clip(pitch, q2e_pkg::PITCH_LIM));
    r.roll  = 16'(clip(roll, q2e_pkg::ROLL_LIM));
    return r;
  endfunction

  // Sample mid-cycle: inputs and outputs are settled, so the next rising
  // edge sees exactly these values.
  always @(negedge clk) begin
    if (rst_n) begin
      taken_now = start && !busy;
      if (out_strobe) begin
        if (angles_pending.size() == 0) begin
          $error("unexpected word: yaw %0d pitch %0d roll %0d", out_yaw_angle,
                 out_pitch_angle, out_roll_angle);
          fail_count++;
        end else begin
          angles_t e;
          e = angles_pending.pop_front();
          if (out_yaw_angle !== e.yaw) begin
            $error("yaw_angle: expected %0d, got %0d", e.yaw, out_yaw_angle);
            fail_count++;
          end
          if (out_pitch_angle !== e.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", e.pitch, out_pitch_angle);
            fail_count++;
          end
          if (out_roll_angle !== e.roll) begin
            $error("roll_angle: expected %0d, got %0d", e.roll, out_roll_angle);
            fail_count++;
          end
          if (out_pitch_clamped !== e.clamped) begin
            $error("pitch_clamped: expected %0d, got %0d", e.clamped, out_pitch_clamped);
            fail_count++;
          end
        end
      end
      // Watchdog: count cycles where nothing moves in either direction.
      if (taken_now || out_strobe) stall_count = 0;
      else stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Present one word and hold it until taken; start stays high afterward so
  // back-to-back words need no second assignment in one step.
  task automatic send_word(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z,
                           bit typed, angles_t typed_angles);
    angles_t predicted;
    start     <= 1'b1;
    in_quat_w <= w;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    do @(negedge clk); while (busy);
    @(posedge clk);
    predicted = euler_of(w, x, y, z);
    if (typed && predicted != typed_angles) begin
      $error("typed row disagrees with predictor: w %0d x %0d y %0d z %0d", w, x, y, z);
      fail_count++;
    end
    angles_pending.push_back(typed ? typed_angles : predicted);
  endtask

  // Drop start for a random gap, often none: mostly short, now and then long.
  task automatic idle_gap();
    int n, pick;
    pick = $urandom_range(99);
    if (pick < 65) n = 0;
    else if (pick < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain the pipeline, then let it run empty for its full depth.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (angles_pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_offset(logic signed [11:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    yaw_offset_copy = v;
  endtask

  function automatic logic signed [15:0] random_component();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 16'($urandom);
    if (pick < 75) return 16'($signed($urandom_range(46340)) - 23170);
    if (pick < 85) return 16'($signed($urandom_range(511)) - 256);
    if (pick < 93) return 16'sd0;
    return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
  endfunction

  quat_row_t directed[$];
  angles_t   none;

  initial begin
    logic signed [11:0] offsets[$];
    start       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_quat_w   <= '0;
    in_quat_x   <= '0;
    in_quat_y   <= '0;
    in_quat_z   <= '0;
    rst_n       <= 1'b0;
    fail_count      = 0;
    stall_count     = 0;
    taken_now       = 1'b0;
    yaw_offset_copy = 12'sd850;
    none = '{default: '0};

    // Zero vector: yaw is just minus the reset offset.
    directed.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
                         '{-16'sd850, 15'sd0, 16'sd0, 1'b0}});
    directed.push_back('{16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b0, none});
    directed.push_back('{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 1'b0, none});
    directed.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sh8000, 1'b0, none});
    directed.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, none});
    directed.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, none});
    directed.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, none});
    // Unnormalized: asin argument saturates both ways.
    directed.push_back('{16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b0, none});
    directed.push_back('{16'sh7fff, 16'sd0, 16'sh8000, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd0, 16'sh7fff, 16'sd0, 16'sh7fff, 1'b0, none});
    directed.push_back('{16'sh8000, 16'sd0, 16'sh7fff, 16'sd0, 1'b0, none});
    // Quarter turns about each axis, pitch right at the asin edge.
    directed.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd23170, 16'sd0, 16'sd0, 16'sd23170, 1'b0, none});
    // Tiny vectors exercise normalization.
    directed.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, none});
    directed.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd1, 1'b0, none});
    directed.push_back('{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, none});
    directed.push_back('{16'sd0, 16'sd1, 16'sd0, 16'sd0, 1'b0, none});
    // Negative denominator with negative numerator: lower half-plane wrap.
    directed.push_back('{-16'sd16384, -16'sd8000, 16'sd20000, 16'sd3000, 1'b0, none});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].w, directed[i].x, directed[i].y, directed[i].z,
                directed[i].typed, directed[i].angles);
      if (i % 3 == 2) idle_gap();
    end

    // Offset phases: width extremes, range extremes, zero, the reset value, then random.
    offsets = '{12'sh800, 12'sh7ff, 12'sd2000, -12'sd2000, 12'sd0, 12'sd850};
    for (int ph = 0; ph < 8; ph++) begin
      write_offset(ph < offsets.size() ? offsets[ph] : 12'($urandom));
      // Run some phases without any gaps at all.
      for (int k = 0; k < RANDOM_WORDS / 8; k++) begin
        send_word(random_component(), random_component(), random_component(),
                  random_component(), 1'b0, none);
        if (ph % 3 != 1) idle_gap();
        // Hold off the sender mid-phase until every word has returned.
        if (ph == 2 && k == 100) drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
